>>> rtl/core/dnc_pkg.sv
package dnc_pkg;

   localparam int CFG_BITS = 12;
   localparam int SAMPLE_PORT_BITS = 16;
   localparam int MASK_BITS = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int THR_SHIFT = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [CFG_BITS-1:0] THRESHOLD_RESET = 12'd12;
   localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RESET = 12'd640;
   localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RESET = 12'd480;

   localparam logic [MASK_BITS-1:0] MASK_FLAT = 8'd0;
   localparam logic [MASK_BITS-1:0] MASK_EDGE = 8'd255;

   localparam int MIN_SIZE = 4;

   typedef logic [CFG_BITS-1:0] cfg_type;

endpackage

>>> rtl/core/decimated_neighbour_contrast_mask.sv
// Decimated 3x3 contrast mask. Signed samples arrive in raster order, one item
// per cycle; frame_start restarts the row and column counts. At every odd row
// and odd column (the last odd ones excluded) the block compares the largest
// absolute difference between the window centre and its eight neighbours with
// threshold*16 and emits mask 255 where it reaches it, 0 otherwise, so the
// output image is (width/2-1) x (height/2-1) with row_end and frame_end marks.
// Throughput is one item per clock while results are taken. The accepting
// edge registers the item and its line-store read, and the window compare
// feeds the result register when that item advances. A result that is not
// taken holds the item behind it and stalls the input. Widths above MAX_WIDTH
// are clamped to MAX_WIDTH. The line store has no reset and needs no clearing
// pass: each entry is written by the row above before a compare uses it.
// Write csr_ registers only while no item is in flight.
module decimated_neighbour_contrast_mask import dnc_pkg::*; #(
   parameter int MAX_WIDTH = 2048,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [SAMPLE_PORT_BITS-1:0] req_sample,
   input  logic                        req_frame_start,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [MASK_BITS-1:0]        rsp_mask,
   output logic                        rsp_row_end,
   output logic                        rsp_frame_end,
   input  logic                        csr_we,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CFG_BITS-1:0]         csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;
   localparam logic [EW-1:0] MAX_WIDTH_E = EW'(MAX_WIDTH);

   cfg_type threshold_ff, image_width_ff, image_height_ff;

   logic [CW-1:0]          col_cnt_ff, col_cnt_in;
   cfg_type                row_cnt_ff, row_cnt_in;
   logic [CW-1:0]          c_cur;
   cfg_type                r_cur;
   logic [EW-1:0]          c_inc;
   logic [CFG_BITS:0]      r_inc;
   logic [EW-1:0]          w_eff;
   logic [EW-1:0]          w_req;

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [CW-1:0]          s1_col_ff;
   cfg_type                s1_row_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MASK_BITS-1:0]   rsp_mask_ff;
   logic                   rsp_row_end_ff, rsp_frame_end_ff;

   logic                   accept, advance;
   logic [SAMPLE_BITS-1:0] rd_top, rd_mid;
   logic                   edge_hit;
   logic                   size_ok, hit, at_lastc, at_lastr;
   logic [EW-1:0]          lastc;
   cfg_type                lastr;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         image_width_ff <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD:    threshold_ff <= csr_wdata;
            CSR_IMAGE_WIDTH:  image_width_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign w_req = EW'(image_width_ff);
   assign w_eff = (w_req > MAX_WIDTH_E) ? MAX_WIDTH_E : w_req;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept = req_valid && req_ready;

   always_comb begin
      c_cur = req_frame_start ? '0 : col_cnt_ff;
      r_cur = req_frame_start ? '0 : row_cnt_ff;
      c_inc = EW'(c_cur) + EW'(1);
      r_inc = {1'b0, r_cur} + (CFG_BITS + 1)'(1);
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept) begin
         if (c_inc >= w_eff) begin
            col_cnt_in = '0;
            row_cnt_in = (r_inc >= {1'b0, image_height_ff}) ? '0 : r_inc[CFG_BITS-1:0];
         end else begin
            col_cnt_in = c_inc[CW-1:0];
            row_cnt_in = r_cur;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample[SAMPLE_BITS-1:0];
         s1_col_ff <= c_cur;
         s1_row_ff <= r_cur;
      end
   end

   dnc_line_store #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (2 * SAMPLE_BITS)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data ({rd_top, rd_mid}),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data ({rd_mid, s1_sample_ff})
   );

   dnc_window #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (advance),
      .top       (rd_top),
      .mid       (rd_mid),
      .sample    (s1_sample_ff),
      .threshold (threshold_ff),
      .edge_hit  (edge_hit)
   );

   always_comb begin
      size_ok = (w_eff >= EW'(MIN_SIZE)) && (image_height_ff >= CFG_BITS'(MIN_SIZE));
      lastc = {w_eff[EW-1:1], 1'b0} - EW'(2);
      lastr = {image_height_ff[CFG_BITS-1:1], 1'b0} - CFG_BITS'(2);
      at_lastc = (EW'(s1_col_ff) == lastc);
      at_lastr = (s1_row_ff == lastr);
      hit = size_ok && (s1_col_ff >= CW'(2)) && (s1_row_ff >= CFG_BITS'(2))
            && !s1_col_ff[0] && !s1_row_ff[0]
            && (EW'(s1_col_ff) <= lastc) && (s1_row_ff <= lastr);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && hit) begin
         rsp_mask_ff <= edge_hit ? MASK_EDGE : MASK_FLAT;
         rsp_row_end_ff <= at_lastc;
         rsp_frame_end_ff <= at_lastc && at_lastr;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mask = rsp_mask_ff;
   assign rsp_row_end = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

>>> rtl/core/dnc_line_store.sv
module dnc_line_store import dnc_pkg::*; #(
   parameter int DEPTH = 2048,
   parameter int DATA_BITS = 32
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward a write that lands on the address being read in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/dnc_window.sv
module dnc_window import dnc_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic [SAMPLE_BITS-1:0] top,
   input  logic [SAMPLE_BITS-1:0] mid,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  cfg_type                threshold,
   output logic                   edge_hit
);

   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int CMP_BITS = (DIFF_BITS > CFG_BITS + THR_SHIFT) ? DIFF_BITS
                                                                : CFG_BITS + THR_SHIFT;

   logic [SAMPLE_BITS-1:0] win_ff [6];
   logic [SAMPLE_BITS-1:0] win_in [6];
   logic [SAMPLE_BITS-1:0] nb [8];
   logic [SAMPLE_BITS-1:0] ctr;
   logic [DIFF_BITS-1:0]   diff [8];
   logic [DIFF_BITS-1:0]   mag [8];
   logic [CMP_BITS-1:0]    limit;
   logic [7:0]             over;

   always_comb begin
      win_in[0] = win_ff[3];
      win_in[1] = win_ff[4];
      win_in[2] = win_ff[5];
      win_in[3] = top;
      win_in[4] = mid;
      win_in[5] = sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_comb begin
      ctr = win_ff[4];
      nb[0] = win_ff[0];
      nb[1] = win_ff[1];
      nb[2] = win_ff[2];
      nb[3] = win_ff[3];
      nb[4] = win_ff[5];
      nb[5] = top;
      nb[6] = mid;
      nb[7] = sample;
      limit = CMP_BITS'({threshold, THR_SHIFT'(0)});
      for (int k = 0; k < 8; k++) begin
         diff[k] = {nb[k][SAMPLE_BITS-1], nb[k]} - {ctr[SAMPLE_BITS-1], ctr};
         mag[k] = diff[k][DIFF_BITS-1] ? (~diff[k] + DIFF_BITS'(1)) : diff[k];
         over[k] = (CMP_BITS'(mag[k]) >= limit);
      end
   end

   assign edge_hit = |over;

endmodule

>>> rtl/core/dnc_checker.sv
module dnc_checker import dnc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [MASK_BITS-1:0] rsp_mask,
   input logic                 rsp_row_end,
   input logic                 rsp_frame_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mask))
      else $error("result item changed while stalled");

   a_mask_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mask == MASK_FLAT) || (rsp_mask == MASK_EDGE))
      else $error("mask is neither flat nor edge");

   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind decimated_neighbour_contrast_mask dnc_checker u_dnc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_mask      (rsp_mask),
   .rsp_row_end   (rsp_row_end),
   .rsp_frame_end (rsp_frame_end)
);

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dnc_pkg::*;

   localparam int LINE_DEPTH = 2048;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_ITEMS = 900;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic [MASK_BITS-1:0] mask;
      logic                 row_end;
      logic                 frame_end;
   } mask_item_type;

   class mask_scoreboard_type;
      int thresh = THRESHOLD_RESET;
      int width = IMAGE_WIDTH_RESET;
      int height = IMAGE_HEIGHT_RESET;
      int upper_row[LINE_DEPTH];
      int middle_row[LINE_DEPTH];
      int taps[6];
      int col = 0;
      int row = 0;
      int errors = 0;
      mask_item_type pending_masks[$];

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, cfg_type val);
         case (idx)
            CSR_THRESHOLD: thresh = val;
            CSR_IMAGE_WIDTH: width = val;
            CSR_IMAGE_HEIGHT: height = val;
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_PORT_BITS-1:0] raw, logic fs);
         int s, w, h, c, r, lastc, lastr, top, mid, ctr, peak, diff;
         int nb[8];
         mask_item_type e;
         s = $signed(raw);
         w = (width > LINE_DEPTH) ? LINE_DEPTH : width;
         h = height;
         if (fs) begin
            col = 0;
            row = 0;
         end
         c = (col >= LINE_DEPTH) ? 0 : col;
         r = row;
         top = upper_row[c];
         mid = middle_row[c];
         if (w / 2 >= 2 && h / 2 >= 2) begin
            lastc = 2 * (w / 2) - 2;
            lastr = 2 * (h / 2) - 2;
            if (c >= 2 && r >= 2 && c % 2 == 0 && r % 2 == 0 &&
                c <= lastc && r <= lastr) begin
               ctr = taps[4];
               nb = '{taps[0], taps[1], taps[2], taps[3], taps[5], top, mid, s};
               peak = 0;
               foreach (nb[k]) begin
                  diff = nb[k] - ctr;
                  if (diff < 0) diff = -diff;
                  if (diff > peak) peak = diff;
               end
               e.mask = (peak < (thresh << THR_SHIFT)) ? MASK_FLAT : MASK_EDGE;
               e.row_end = (c == lastc);
               e.frame_end = (c == lastc && r == lastr);
               pending_masks.push_back(e);
            end
         end
         taps[0] = taps[3];
         taps[1] = taps[4];
         taps[2] = taps[5];
         taps[3] = top;
         taps[4] = mid;
         taps[5] = s;
         upper_row[c] = mid;
         middle_row[c] = s;
         if (c + 1 >= w) begin
            col = 0;
            row = (r + 1 >= h) ? 0 : ((r + 1) & 'hFFF);
         end else begin
            col = (c + 1) & 'h7FF;
            row = r;
         end
      endfunction

      function void check_mask(logic [MASK_BITS-1:0] m, logic re, logic fe);
         mask_item_type e;
         if (pending_masks.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: mask %0d row_end %0b frame_end %0b",
                     $time, m, re, fe);
            return;
         end
         e = pending_masks.pop_front();
         if (m !== e.mask) begin
            errors++;
            $display("%0t: mask expected %0d actual %0d", $time, e.mask, m);
         end
         if (re !== e.row_end) begin
            errors++;
            $display("%0t: row_end expected %0b actual %0b", $time, e.row_end, re);
         end
         if (fe !== e.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %0b actual %0b", $time, e.frame_end, fe);
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [SAMPLE_PORT_BITS-1:0] req_sample = '0;
   logic                        req_frame_start = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [MASK_BITS-1:0]        rsp_mask;
   logic                        rsp_row_end;
   logic                        rsp_frame_end;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = CSR_THRESHOLD;
   cfg_type                     csr_wdata = '0;

   mask_scoreboard_type sb;
   int burst_left = 0;
   int ready_mode = 0;
   int ready_hold = 0;

   decimated_neighbour_contrast_mask uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mask(rsp_mask),
      .rsp_row_end(rsp_row_end),
      .rsp_frame_end(rsp_frame_end),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_sample(req_sample, req_frame_start);
         if (rsp_valid && rsp_ready) sb.check_mask(rsp_mask, rsp_row_end, rsp_frame_end);
      end
   end

   always @(negedge clock) begin
      if (ready_hold == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_hold = $urandom_range(20, 200);
      end else begin
         ready_hold--;
      end
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= (ready_hold % 4 != 0);
         default: rsp_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   task automatic send_item(input logic [SAMPLE_PORT_BITS-1:0] smp, input logic fs);
      int gap;
      req_valid <= 1'b1;
      req_sample <= smp;
      req_frame_start <= fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_masks.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= cfg_type'(val);
      sb.write_reg(idx, cfg_type'(val));
      @(negedge clock);
   endtask

   task automatic set_geometry(input int thr, input int w, input int h);
      wait_idle();
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_PORT_BITS-1:0] pick_sample(int base, int spread);
      if ($urandom_range(0, 15) == 0) return SAMPLE_PORT_BITS'($urandom);
      return SAMPLE_PORT_BITS'(base + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   task automatic run_phase(input int thr, input int w, input int h, input int n);
      int base, spread;
      base = int'($urandom_range(0, 65535)) - 32768;
      spread = $urandom_range(0, thr * 16 + 64);
      set_geometry(thr, w, h);
      for (int k = 0; k < n; k++)
         send_item(pick_sample(base, spread), k == 0 || $urandom_range(0, 99) == 0);
   endtask

   initial begin
      int random_sent, w, h, t, n, guard;
      logic [SAMPLE_PORT_BITS-1:0] smp;
      sb = new();
      random_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 4x6 frame at the top threshold: full-scale step, then one step just short
      set_geometry(4095, 4, 6);
      for (int r = 0; r < 6; r++) begin
         for (int c = 0; c < 4; c++) begin
            smp = 16'h8000;
            if (r == 0 && c == 0) smp = 16'h7FFF;
            if (r == 4 && c == 2) smp = 16'h7FEF;
            send_item(smp, r == 0 && c == 0);
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 40) : $urandom_range(4, 12);
         h = $urandom_range(4, 10);
         case ($urandom_range(0, 5))
            0: t = 0;
            1: t = 4095;
            2: t = $urandom_range(0, 4095);
            default: t = $urandom_range(0, 255);
         endcase
         n = w * h * $urandom_range(1, 3) + $urandom_range(0, w * h - 1);
         run_phase(t, w, h, n);
         random_sent += n;
      end

      run_phase($urandom_range(0, 255), LINE_DEPTH, 4, LINE_DEPTH / 8);
      run_phase($urandom_range(0, 255), 4, 4095, 160);
      run_phase(THRESHOLD_RESET, 5, 7, 70);

      req_valid <= 1'b0;
      guard = 0;
      while (sb.pending_masks.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      if (sb.pending_masks.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected items never arrived", $time, sb.pending_masks.size());
      end
      repeat (2 * DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

>>> sim.f
rtl/core/dnc_pkg.sv
rtl/core/dnc_line_store.sv
rtl/core/dnc_window.sv
rtl/core/decimated_neighbour_contrast_mask.sv
rtl/core/dnc_checker.sv
tb/tb.sv
